// File: src/magma_block_cipher_core_macros.svh
// Assertion macros for the cipher core RTL (used by the queue)
`ifndef MAGMA_BLOCK_CIPHER_CORE_MACROS_SVH
`define MAGMA_BLOCK_CIPHER_CORE_MACROS_SVH

// same-cycle implication
`define MGM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MGM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mgm_pkg.sv
// Types, constants and round helpers for the Magma cipher core
package mgm_pkg;

  localparam int BLOCK_W     = 64;
  localparam int HALF_W      = 32;
  localparam int KEY_W       = 256;
  localparam int ROUNDS      = 32;
  localparam int ROT_AMOUNT  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic                 decrypt;
    logic [BLOCK_W-1:0]   block;
  } entry_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_MODE = 3'd4
  } reg_idx_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd11, 4'd7, 4'd13, 4'd0, 4'd4, 4'd15, 4'd14},
    '{4'd7, 4'd11, 4'd5, 4'd8, 4'd12, 4'd4, 4'd2, 4'd0,
      4'd14, 4'd1, 4'd3, 4'd10, 4'd9, 4'd15, 4'd6, 4'd13},
    '{4'd13, 4'd1, 4'd7, 4'd4, 4'd11, 4'd5, 4'd0, 4'd15,
      4'd3, 4'd12, 4'd14, 4'd6, 4'd9, 4'd10, 4'd2, 4'd8},
    '{4'd5, 4'd10, 4'd15, 4'd12, 4'd1, 4'd13, 4'd14, 4'd11,
      4'd8, 4'd3, 4'd6, 4'd0, 4'd4, 4'd7, 4'd9, 4'd2},
    '{4'd14, 4'd5, 4'd0, 4'd15, 4'd13, 4'd11, 4'd3, 4'd6,
      4'd9, 4'd2, 4'd12, 4'd7, 4'd1, 4'd8, 4'd10, 4'd4},
    '{4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd5,
      4'd0, 4'd9, 4'd4, 4'd15, 4'd2, 4'd8, 4'd1, 4'd6},
    '{4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd0, 4'd11, 4'd4,
      4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd10, 4'd8, 4'd5}
  };

  // key word number (0 = K1) used by a given round position
  function automatic int key_index(int r);
    return (r < 24) ? (r & 7) : (7 - (r & 7));
  endfunction

  // round function: add key, substitute nibbles, rotate left
  function automatic logic [HALF_W-1:0] round_fn(logic [HALF_W-1:0] half,
                                                 logic [HALF_W-1:0] k);
    logic [HALF_W-1:0] sum;
    logic [HALF_W-1:0] sub;
    sum = half + k;
    sub = '0;
    for (int i = 0; i < 8; i++) begin
      sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
    end
    return {sub[HALF_W-ROT_AMOUNT-1:0], sub[HALF_W-1:HALF_W-ROT_AMOUNT]};
  endfunction

endpackage

// File: src/mgm_front.sv
// Front end: takes commands, tags each word with its mode, feeds the queue
module mgm_front #(
  parameter int DEPTH = mgm_pkg::QUEUE_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mgm_pkg::BLOCK_W-1:0] in_block_in,
  input  logic                        decrypt_mode,
  input  logic [LW-1:0]               level,
  output logic                        busy,
  output logic                        push,
  output mgm_pkg::entry_t             entry
);

  logic            valid_r;
  logic            valid_nxt;
  mgm_pkg::entry_t entry_r;
  logic [LW:0]     fill;

  // queue level plus the word still held here
  assign fill      = {1'b0, level} + {{LW{1'b0}}, valid_r};
  assign busy      = (fill >= (LW + 1)'(DEPTH));
  assign valid_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      entry_r.decrypt <= decrypt_mode;
      entry_r.block   <= in_block_in;
    end
  end

  assign push  = valid_r;
  assign entry = entry_r;

endmodule

// File: src/mgm_queue.sv
// Short queue between front end and round pipeline
`include "magma_block_cipher_core_macros.svh"

module mgm_queue #(
  parameter int DEPTH = mgm_pkg::QUEUE_DEPTH,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mgm_pkg::entry_t wr_entry,
  input  logic            pop,
  output mgm_pkg::entry_t rd_entry,
  output logic            empty,
  output logic [LW-1:0]   level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mgm_pkg::entry_t mem_r [DEPTH];
  mgm_pkg::entry_t rd_entry_r;
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [LW-1:0]   count_r;
  logic [LW-1:0]   count_nxt;
  logic            do_pop;

  assign empty  = (count_r == '0);
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // head word held in a register; a word written to the next head slot passes straight in
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_entry_r <= wr_entry;
    end else begin
      rd_entry_r <= mem_r[rd_ptr_nxt];
    end
  end

  assign rd_entry = rd_entry_r;
  assign level    = count_r;

  `MGM_ASSERT_NOW(a_no_overflow, push && !do_pop, count_r < LW'(DEPTH), "queue overflow")
  `MGM_ASSERT_NEXT(a_count_up, push && !do_pop, count_r == $past(count_r) + 1'b1, "count up")
  `MGM_ASSERT_NEXT(a_ptr_gap, 1'b1,
    (count_r == LW'(DEPTH)) || (count_r == '0) ? (wr_ptr_r == rd_ptr_r) : (wr_ptr_r != rd_ptr_r),
    "pointer and count disagree")

endmodule

// File: src/mgm_back.sv
// Round pipeline: one Feistel round per stage
module mgm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  mgm_pkg::entry_t             entry_i,
  input  mgm_pkg::key_t               key,
  output logic                        out_valid,
  output logic [mgm_pkg::BLOCK_W-1:0] out_block_out
);

  localparam int N  = mgm_pkg::ROUNDS;
  localparam int HW = mgm_pkg::HALF_W;

  logic          v_r    [N];
  logic          mode_r [N];
  logic [HW-1:0] hi_r   [N];
  logic [HW-1:0] lo_r   [N];
  logic [HW-1:0] hi_nxt [N];
  logic [HW-1:0] lo_nxt [N];

  for (genvar r = 0; r < N; r++) begin : g_round
    localparam int ENC_N = mgm_pkg::key_index(r);
    localparam int DEC_N = mgm_pkg::key_index(N - 1 - r);

    logic          v_in;
    logic          mode_in;
    logic [HW-1:0] hi_in;
    logic [HW-1:0] lo_in;
    logic [HW-1:0] rk;

    if (r == 0) begin : g_first
      assign v_in    = valid_i;
      assign mode_in = entry_i.decrypt;
      assign hi_in   = entry_i.block[2*HW-1:HW];
      assign lo_in   = entry_i.block[HW-1:0];
    end else begin : g_next
      assign v_in    = v_r[r-1];
      assign mode_in = mode_r[r-1];
      assign hi_in   = hi_r[r-1];
      assign lo_in   = lo_r[r-1];
    end

    assign rk = mode_in ? key[mgm_pkg::KEY_W-1-HW*DEC_N -: HW]
                        : key[mgm_pkg::KEY_W-1-HW*ENC_N -: HW];
    assign hi_nxt[r] = lo_in;
    assign lo_nxt[r] = hi_in ^ mgm_pkg::round_fn(lo_in, rk);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[r] <= 1'b0;
      end else begin
        v_r[r] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      mode_r[r] <= mode_in;
      hi_r[r]   <= hi_nxt[r];
      lo_r[r]   <= lo_nxt[r];
    end
  end

  assign out_valid     = v_r[N-1];
  assign out_block_out = {lo_r[N-1], hi_r[N-1]};

endmodule

// File: src/magma_block_cipher_core.sv
// Top level of the Magma 64-bit block cipher core
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+--------------------------
//  input    | start, busy                       | in_block_in[63:0]
//  result   | out_valid (one-cycle strobe)      | out_block_out[63:0]
//  config   | psel, penable, pwrite, pready     | paddr[5:0], pwdata, prdata
//
// One word per cycle sustained while busy is low; each word passes the front
// register, queue slot and the 32-stage round pipeline, one round per stage.
// Synchronous active-low reset clears keys, mode, queue and stage valid bits.
// The result side never stalls; busy rises only if the queue fills.
module magma_block_cipher_core #(
  parameter int QUEUE_DEPTH = mgm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [mgm_pkg::BLOCK_W-1:0] in_block_in,
  output logic                        out_valid,
  output logic [mgm_pkg::BLOCK_W-1:0] out_block_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mgm_pkg::ADDR_W-1:0]  paddr,
  input  logic [mgm_pkg::DATA_W-1:0]  pwdata,
  output logic [mgm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic [mgm_pkg::DATA_W-1:0] key0_r;
  logic [mgm_pkg::DATA_W-1:0] key1_r;
  logic [mgm_pkg::DATA_W-1:0] key2_r;
  logic [mgm_pkg::DATA_W-1:0] key3_r;
  logic                       mode_r;
  logic                       wr_en;
  logic [2:0]                 reg_idx;

  logic            push;
  mgm_pkg::entry_t fe_entry;
  mgm_pkg::entry_t q_entry;
  logic            q_empty;
  logic [LW-1:0]   q_level;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      mode_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        mgm_pkg::REG_KEY0: key0_r <= pwdata;
        mgm_pkg::REG_KEY1: key1_r <= pwdata;
        mgm_pkg::REG_KEY2: key2_r <= pwdata;
        mgm_pkg::REG_KEY3: key3_r <= pwdata;
        mgm_pkg::REG_MODE: mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mgm_pkg::REG_KEY0: prdata = key0_r;
      mgm_pkg::REG_KEY1: prdata = key1_r;
      mgm_pkg::REG_KEY2: prdata = key2_r;
      mgm_pkg::REG_KEY3: prdata = key3_r;
      mgm_pkg::REG_MODE: prdata = {{(mgm_pkg::DATA_W-1){1'b0}}, mode_r};
      default:           prdata = '0;
    endcase
  end

  mgm_front #(
    .DEPTH (QUEUE_DEPTH),
    .LW    (LW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_block_in  (in_block_in),
    .decrypt_mode (mode_r),
    .level        (q_level),
    .busy         (busy),
    .push         (push),
    .entry        (fe_entry)
  );

  mgm_queue #(
    .DEPTH (QUEUE_DEPTH),
    .LW    (LW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (fe_entry),
    .pop      (!q_empty),
    .rd_entry (q_entry),
    .empty    (q_empty),
    .level    (q_level)
  );

  mgm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (!q_empty),
    .entry_i       (q_entry),
    .key           ({key0_r, key1_r, key2_r, key3_r}),
    .out_valid     (out_valid),
    .out_block_out (out_block_out)
  );

endmodule

// File: verif/magma_block_cipher_core_checker.sv
// Magma core checker: follows key and mode writes, predicts each block and compares results
module magma_block_cipher_core_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [mgm_pkg::BLOCK_W-1:0] in_block_in,
  input  logic                        out_valid,
  input  logic [mgm_pkg::BLOCK_W-1:0] out_block_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mgm_pkg::ADDR_W-1:0]  paddr,
  input  logic [mgm_pkg::DATA_W-1:0]  pwdata,
  output int                          mismatches,
  output int                          blocks_in_flight
);

  localparam logic [3:0] SUBST [8][16] = '{
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
      4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
    '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
      4'd1, 4'd11, 4'd7, 4'd13, 4'd0, 4'd4, 4'd15, 4'd14},
    '{4'd7, 4'd11, 4'd5, 4'd8, 4'd12, 4'd4, 4'd2, 4'd0,
      4'd14, 4'd1, 4'd3, 4'd10, 4'd9, 4'd15, 4'd6, 4'd13},
    '{4'd13, 4'd1, 4'd7, 4'd4, 4'd11, 4'd5, 4'd0, 4'd15,
      4'd3, 4'd12, 4'd14, 4'd6, 4'd9, 4'd10, 4'd2, 4'd8},
    '{4'd5, 4'd10, 4'd15, 4'd12, 4'd1, 4'd13, 4'd14, 4'd11,
      4'd8, 4'd3, 4'd6, 4'd0, 4'd4, 4'd7, 4'd9, 4'd2},
    '{4'd14, 4'd5, 4'd0, 4'd15, 4'd13, 4'd11, 4'd3, 4'd6,
      4'd9, 4'd2, 4'd12, 4'd7, 4'd1, 4'd8, 4'd10, 4'd4},
    '{4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd5,
      4'd0, 4'd9, 4'd4, 4'd15, 4'd2, 4'd8, 4'd1, 4'd6},
    '{4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd0, 4'd11, 4'd4,
      4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd10, 4'd8, 4'd5}
  };

  logic [63:0] key_parts [4];
  logic        decrypt_on;
  logic [63:0] expected_blocks [$];
  logic [63:0] want;
  int          fail_total = 0;
  int          in_flight = 0;

  assign mismatches       = fail_total;
  assign blocks_in_flight = in_flight;

  // 32-bit key word n, n = 0 is the top half of the first key part
  function automatic logic [31:0] key_word(int n);
    logic [63:0] part;
    part = key_parts[n / 2];
    return (n % 2 == 1) ? part[31:0] : part[63:32];
  endfunction

  function automatic logic [31:0] round_mix(logic [31:0] half, logic [31:0] k);
    logic [31:0] sum;
    logic [31:0] s;
    sum = half + k;
    for (int i = 0; i < 8; i++) begin
      s[4*i +: 4] = SUBST[i][sum[4*i +: 4]];
    end
    return {s[20:0], s[31:21]};
  endfunction

  function automatic logic [63:0] cipher_block(logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] nlo;
    int          pos;
    int          kn;
    hi = blk[63:32];
    lo = blk[31:0];
    for (int r = 0; r < 32; r++) begin
      pos = decrypt_on ? 31 - r : r;
      kn  = (pos < 24) ? pos % 8 : 7 - pos % 8;
      nlo = hi ^ round_mix(lo, key_word(kn));
      hi  = lo;
      lo  = nlo;
    end
    return {lo, hi};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_blk);
    $display("[%0t] block mismatch: %s: got %h, want %h", $time, what, got, exp_blk);
    fail_total++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_parts[i] = '0;
      end
      decrypt_on = 1'b0;
      expected_blocks.delete();
    end else begin
      if ($isunknown(out_valid)) begin
        report_mismatch("unknown strobe", out_block_out, '0);
      end else if (out_valid) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("word with nothing pending", out_block_out, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (out_block_out !== want) begin
            report_mismatch("block_out", out_block_out, want);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_blocks.push_back(cipher_block(in_block_in));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          mgm_pkg::REG_KEY0: key_parts[0] = pwdata;
          mgm_pkg::REG_KEY1: key_parts[1] = pwdata;
          mgm_pkg::REG_KEY2: key_parts[2] = pwdata;
          mgm_pkg::REG_KEY3: key_parts[3] = pwdata;
          mgm_pkg::REG_MODE: decrypt_on = pwdata[0];
          default: ;
        endcase
      end
    end
    in_flight <= expected_blocks.size();
  end

endmodule

// File: verif/magma_block_cipher_core_test.sv
// Magma core testbench top: drives blocks and key/mode writes, gives the verdict
module magma_block_cipher_core_test;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int RANDOM_PHASES    = 12;
  localparam int BLOCKS_PER_PHASE = 125;
  localparam int TAIL_CYCLES      = 40;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [mgm_pkg::BLOCK_W-1:0] in_block_in;
  logic                        out_valid;
  logic [mgm_pkg::BLOCK_W-1:0] out_block_out;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mgm_pkg::ADDR_W-1:0]  paddr;
  logic [mgm_pkg::DATA_W-1:0]  pwdata;
  logic [mgm_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  int                          mismatches;
  int                          blocks_in_flight;
  int                          cycle_count = 0;

  magma_block_cipher_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_block_out (out_block_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  magma_block_cipher_core_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_block_in      (in_block_in),
    .out_valid        (out_valid),
    .out_block_out    (out_block_out),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatches       (mismatches),
    .blocks_in_flight (blocks_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [63:0] pick_block();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return 64'd1 << $urandom_range(0, 63);
    if (r == 3) return ~(64'd1 << $urandom_range(0, 63));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key_part();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] p0, input logic [63:0] p1,
                           input logic [63:0] p2, input logic [63:0] p3);
    write_reg(mgm_pkg::REG_KEY0, p0);
    write_reg(mgm_pkg::REG_KEY1, p1);
    write_reg(mgm_pkg::REG_KEY2, p2);
    write_reg(mgm_pkg::REG_KEY3, p3);
  endtask

  // start stays high across back-to-back words; lowered only for a gap
  task automatic send_block(input logic [63:0] w, input bit no_gaps);
    int gap;
    start       <= 1'b1;
    in_block_in <= w;
    do @(posedge clk); while (busy !== 1'b0);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (blocks_in_flight != 0) @(posedge clk);
  endtask

  initial begin
    bit          no_gaps;
    logic [63:0] mode_word;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_block_in <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys (all zero), encrypt, full rate
    send_block(64'h0, 1'b1);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0000_0000_0000_0001, 1'b1);
    send_block(64'h8000_0000_0000_0000, 1'b1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_block(64'h5555_5555_5555_5555, 1'b1);
    drain();

    // standard key; wide mode word with bit 0 clear still encrypts
    write_key(64'hFFEE_DDCC_BBAA_9988, 64'h7766_5544_3322_1100,
              64'hF0F1_F2F3_F4F5_F6F7, 64'hF8F9_FAFB_FCFD_FEFF);
    write_reg(mgm_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_block(64'hFEDC_BA98_7654_3210, 1'b0);
    send_block(64'h0, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    drain();

    write_reg(mgm_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(64'h4EE9_01E5_C2D8_CA3D, 1'b0);
    send_block(64'hFEDC_BA98_7654_3210, 1'b0);
    drain();

    // writes past the last register must leave the key alone; the key is then set to all ones anyway
    for (int i = int'(mgm_pkg::REG_MODE) + 1; i < 8; i++) begin
      write_reg(3'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    end
    write_key('1, '1, '1, '1);
    write_reg(mgm_pkg::REG_MODE, 64'h2);
    send_block(64'h0, 1'b1);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_block(64'h0123_4567_89AB_CDEF, 1'b1);
    drain();

    write_reg(mgm_pkg::REG_MODE, 64'h1);
    send_block(64'h0, 1'b0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_key(pick_key_part(), pick_key_part(), pick_key_part(), pick_key_part());
      mode_word = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
      mode_word[0] = ph[0];
      write_reg(mgm_pkg::REG_MODE, mode_word);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(3'($urandom_range(int'(mgm_pkg::REG_MODE) + 1, 7)), {$urandom, $urandom});
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        send_block(pick_block(), no_gaps);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
